FILE: rtl/astlr_pkg.sv
// ----------------------------------------------------------------------------
// astlr_pkg: shared types and constants of the aftertouch second layer router
// Message kinds, queue item and result layouts, status nibbles and
// register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package astlr_pkg;

    // status nibbles
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_KEY_PRESS  = 4'hA;
    localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;

    localparam logic [1:0] GEN_COUNT  = 2'd3;
    localparam logic       DEST_MAIN  = 1'b0;
    localparam logic       DEST_LAYER = 1'b1;

    // configuration register indexes
    localparam logic [0:0] REG_ON_THR  = 1'b0;
    localparam logic [0:0] REG_OFF_THR = 1'b1;

    localparam logic [6:0] ON_THR_RESET  = 7'd96;
    localparam logic [6:0] OFF_THR_RESET = 7'd32;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_NOTE = 2'd1,
        KIND_KEYP = 2'd2,
        KIND_CHP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
        logic [1:0] count;
        kind_t      kind;
    } item_t;

    typedef struct packed {
        logic       dest;
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
        logic [1:0] count;
        logic       last;
        logic       trunc;
    } result_t;

endpackage

FILE: rtl/aftertouch_second_layer_router_core.sv
// ----------------------------------------------------------------------------
// aftertouch_second_layer_router_core: MIDI note and pressure router
// Path: an input beat passes the queue, the item register and the output register,
// with stalls possible between; when the layer is on, a forwarded note follows its
// second layer copy. Messages are handled one at a time; channel pressure that walks
// the notes steps through one stored note per cycle while the output is not stalled.
// Reset: synchronous; per-note valid bits make the velocity store and layer
// flags read as zero at once, and the thresholds return to 96 and 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aftertouch_second_layer_router_core #(
    parameter int NOTE_COUNT  = 128,
    parameter int BURST_LIMIT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // status_byte, first_data, second_data, byte_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_status, out_first, out_second, out_count
    output logic [1:0]  m_tuser,   // destination, truncated
    output logic        m_tlast
);
    import astlr_pkg::*;

    item_t   push_item;
    item_t   head_item;
    logic    q_push, q_pop, q_empty, q_full;
    result_t result;

    astlr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    astlr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    astlr_back #(
        .NOTE_COUNT  (NOTE_COUNT),
        .BURST_LIMIT (BURST_LIMIT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_item    (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {result.count, result.second, result.first, result.status};
    assign m_tuser = {result.trunc, result.dest};
    assign m_tlast = result.last;

endmodule

FILE: rtl/astlr_front.sv
// ----------------------------------------------------------------------------
// astlr_front: input side of the router
// Unpacks the input beat, decodes the message kind from the status nibble
// and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module astlr_front (
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [23:0]     s_tdata,
    input  logic            q_full,
    output logic            q_push,
    output astlr_pkg::item_t q_item
);
    import astlr_pkg::*;

    kind_t kind;

    always_comb begin
        unique case (s_tdata[7:4])
            NIB_NOTE_OFF, NIB_NOTE_ON: kind = KIND_NOTE;
            NIB_KEY_PRESS:             kind = KIND_KEYP;
            NIB_CHAN_PRESS:            kind = KIND_CHP;
            default:                   kind = KIND_PASS;
        endcase
    end

    assign s_tready      = !q_full;
    assign q_push        = s_tvalid && !q_full;
    assign q_item.status = s_tdata[7:0];
    assign q_item.first  = s_tdata[14:8];
    assign q_item.second = s_tdata[21:15];
    assign q_item.count  = s_tdata[23:22];
    assign q_item.kind   = kind;

endmodule

FILE: rtl/astlr_queue.sv
// ----------------------------------------------------------------------------
// astlr_queue: short item queue between front and back
// Two-entry FIFO so either side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module astlr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  astlr_pkg::item_t push_item,
    input  logic             pop,
    output astlr_pkg::item_t head_item,
    output logic             empty,
    output logic             full
);
    import astlr_pkg::*;

    item_t           slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign empty     = (fill_reg == '0);
    assign full      = (fill_reg == (Q_AW + 1)'(Q_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/astlr_back.sv
// ----------------------------------------------------------------------------
// astlr_back: execution side of the router
// Holds the thresholds, the layer flag, the velocity memory and the held
// note count; forwards, mirrors and walks notes into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module astlr_back #(
    parameter int NOTE_COUNT  = 128,
    parameter int BURST_LIMIT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  astlr_pkg::item_t   q_item,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output astlr_pkg::result_t m_result
);
    import astlr_pkg::*;

    localparam int AW = $clog2(NOTE_COUNT);
    localparam int CW = $clog2(NOTE_COUNT + 1);
    localparam int BW = $clog2(BURST_LIMIT + 1);
    localparam logic [7:0] NOTE_LIM  = 8'(NOTE_COUNT);
    localparam logic [7:0] BURST_LIM = 8'(BURST_LIMIT);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MIRROR = 5'b00010,
        S_MAIN   = 5'b00100,
        S_KEYP   = 5'b01000,
        S_WALK   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [AW-1:0]   note_reg, note_next;
    logic [BW-1:0]   emitted_reg, emitted_next;
    logic [BW-1:0]   total_reg, total_next;
    logic            trunc_reg, trunc_next;
    logic            mode_on_reg, mode_on_next;
    logic            global_reg, global_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [6:0]      on_thr_reg, off_thr_reg;
    logic [NOTE_COUNT-1:0] valid_reg;
    logic [7:0]      vel_mem [NOTE_COUNT];
    logic [7:0]      rdata_reg;
    logic            rvld_reg;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;
    logic            out_load;
    logic            wr_en;
    logic [7:0]      wr_data;
    logic            chp_go;

    logic [7:0]      rd_entry;
    logic [6:0]      vel;
    logic            lay;
    logic            in_range;
    logic            free;
    logic [3:0]      ch;
    logic            is_on;
    logic [6:0]      new_vel;
    logic            walk_last;

    // entries never written read as zero
    assign rd_entry  = rvld_reg ? rdata_reg : 8'h00;
    assign vel       = rd_entry[6:0];
    assign lay       = rd_entry[7];
    assign in_range  = ({1'b0, item_reg.first} < NOTE_LIM);
    assign free      = !out_valid_reg || m_ready;
    assign ch        = item_reg.status[3:0];
    assign is_on     = (item_reg.status[7:4] == NIB_NOTE_ON);
    assign new_vel   = is_on ? item_reg.second : 7'd0;
    assign walk_last = ((emitted_reg + BW'(1)) == total_reg);

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        note_next      = note_reg;
        emitted_next   = emitted_reg;
        total_next     = total_reg;
        trunc_next     = trunc_reg;
        mode_on_next   = mode_on_reg;
        global_next    = global_reg;
        count_next     = count_reg;
        q_pop          = 1'b0;
        chp_go         = 1'b0;
        wr_en          = 1'b0;
        wr_data        = rd_entry;
        out_load       = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    note_next = q_item.first[AW-1:0];
                    unique case (q_item.kind)
                        KIND_PASS: state_next = S_MAIN;
                        KIND_NOTE: state_next = global_reg ? S_MIRROR : S_MAIN;
                        KIND_KEYP: state_next = S_KEYP;
                        KIND_CHP: begin
                            priority if (q_item.first >= on_thr_reg && !global_reg) begin
                                chp_go       = 1'b1;
                                mode_on_next = 1'b1;
                                global_next  = 1'b1;
                            end else if (q_item.first < off_thr_reg && global_reg) begin
                                chp_go       = 1'b1;
                                mode_on_next = 1'b0;
                                global_next  = 1'b0;
                            end
                            // walk only when some note is held
                            if (chp_go && count_reg != '0) begin
                                note_next    = '0;
                                emitted_next = '0;
                                trunc_next   = (8'(count_reg) > BURST_LIM);
                                total_next   = (8'(count_reg) > BURST_LIM) ?
                                               BW'(BURST_LIMIT) : BW'(count_reg);
                                state_next   = S_WALK;
                            end
                        end
                        default: state_next = S_MAIN;
                    endcase
                end
            end

            S_MIRROR: begin
                if (free) begin
                    out_load        = 1'b1;
                    out_next.dest   = DEST_LAYER;
                    out_next.status = {is_on ? NIB_NOTE_ON : NIB_NOTE_OFF, ch};
                    out_next.first  = item_reg.first;
                    out_next.second = new_vel;
                    out_next.count  = GEN_COUNT;
                    out_next.last   = 1'b0;
                    out_next.trunc  = 1'b0;
                    state_next      = S_MAIN;
                end
            end

            S_MAIN: begin
                if (free) begin
                    out_load        = 1'b1;
                    out_next.dest   = DEST_MAIN;
                    out_next.status = item_reg.status;
                    out_next.first  = item_reg.first;
                    out_next.second = item_reg.second;
                    out_next.count  = item_reg.count;
                    out_next.last   = 1'b1;
                    out_next.trunc  = 1'b0;
                    state_next      = S_IDLE;
                    if (item_reg.kind == KIND_NOTE && in_range) begin
                        wr_en   = 1'b1;
                        wr_data = {lay, new_vel};
                        if (vel == 7'd0 && new_vel != 7'd0) begin
                            count_next = count_reg + CW'(1);
                        end else if (vel != 7'd0 && new_vel == 7'd0) begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end

            S_KEYP: begin
                priority if (item_reg.second >= on_thr_reg && !(in_range && lay)
                             && in_range && vel != 7'd0) begin
                    if (free) begin
                        out_load        = 1'b1;
                        out_next.dest   = DEST_LAYER;
                        out_next.status = {NIB_NOTE_ON, ch};
                        out_next.first  = item_reg.first;
                        out_next.second = vel;
                        out_next.count  = GEN_COUNT;
                        out_next.last   = 1'b1;
                        out_next.trunc  = 1'b0;
                        wr_en           = 1'b1;
                        wr_data         = {1'b1, vel};
                        state_next      = S_IDLE;
                    end
                end else if (item_reg.second < off_thr_reg && in_range && lay) begin
                    if (free) begin
                        out_load        = 1'b1;
                        out_next.dest   = DEST_LAYER;
                        out_next.status = {NIB_NOTE_OFF, ch};
                        out_next.first  = item_reg.first;
                        out_next.second = 7'd0;
                        out_next.count  = GEN_COUNT;
                        out_next.last   = 1'b1;
                        out_next.trunc  = 1'b0;
                        wr_en           = 1'b1;
                        wr_data         = {1'b0, vel};
                        state_next      = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end

            S_WALK: begin
                if (vel != 7'd0) begin
                    if (free) begin
                        out_load        = 1'b1;
                        out_next.dest   = DEST_LAYER;
                        out_next.status = {mode_on_reg ? NIB_NOTE_ON : NIB_NOTE_OFF, ch};
                        out_next.first  = 7'(note_reg);
                        out_next.second = mode_on_reg ? vel : 7'd0;
                        out_next.count  = GEN_COUNT;
                        out_next.last   = walk_last;
                        out_next.trunc  = trunc_reg;
                        emitted_next    = emitted_reg + BW'(1);
                        if (walk_last) begin
                            state_next = S_IDLE;
                        end else begin
                            note_next = note_reg + AW'(1);
                        end
                    end
                end else begin
                    note_next = note_reg + AW'(1);
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            global_reg    <= 1'b0;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            on_thr_reg    <= ON_THR_RESET;
            off_thr_reg   <= OFF_THR_RESET;
        end else begin
            state_reg     <= state_next;
            global_reg    <= global_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (wr_en) begin
                valid_reg[note_reg] <= 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_ON_THR:  on_thr_reg  <= cfg_wdata;
                    REG_OFF_THR: off_thr_reg <= cfg_wdata;
                    default:     on_thr_reg  <= on_thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        note_reg    <= note_next;
        emitted_reg <= emitted_next;
        total_reg   <= total_next;
        trunc_reg   <= trunc_next;
        mode_on_reg <= mode_on_next;
        rvld_reg    <= valid_reg[note_next];
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // velocity memory: {layer, velocity}, read every cycle at the next note
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vel_mem[note_reg] <= wr_data;
        end
        rdata_reg <= vel_mem[note_next];
    end

endmodule

FILE: rtl/astlr_checker.sv
// ----------------------------------------------------------------------------
// astlr_checker: port checks for the router
// Watches the result channel: beat holding, main beats being last and not truncated,
// and the shape of generated second layer messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module astlr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_layer_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[23:22] == 2'd3 && (m_tdata[7:4] == 4'h9 || m_tdata[7:4] == 4'h8))
        else $error("second layer beat is not a full note message");

    a_main_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1])
        else $error("main output beat not last or flagged truncated");

    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tdata[7:4] == 4'h8 |-> m_tdata[21:15] == 7'd0)
        else $error("generated note off carries a velocity");

endmodule

bind aftertouch_second_layer_router_core astlr_checker u_astlr_checker (.*);
